@@ rtl/core/ffha_pkg.sv @@
// Shared constants and types of the first-fit heap allocator.
// Used by ffha_cell and first_fit_heap_allocator_unit; no dependencies.
`default_nettype none

package ffha_pkg;

   // fixed field widths of the ports
   localparam int REQ_W      = 20;
   localparam int ADDR_W     = 20;
   localparam int STAT_W     = 3;
   localparam int MAXREQ_W   = 20;
   localparam int LIMIT_W    = 21;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 21;

   // parameter defaults
   localparam int DEF_MAX_BLOCKS      = 64;
   localparam int DEF_ARENA_ADDR_BITS = 20;
   localparam int DEF_HEADER_BYTES    = 32;
   localparam int DEF_ALIGN_BYTES     = 16;

   // smallest payload a split-off remainder must keep
   localparam int MIN_TAIL_BYTES = 16;

   // round-up by reciprocal: q < 2^21, align <= 64
   localparam int RND_Q_W    = REQ_W + 1;
   localparam int RND_SHIFT  = RND_Q_W + 7;
   localparam int RND_MUL_W  = 27;
   localparam int RND_PROD_W = RND_Q_W + RND_MUL_W;
   localparam int RND_QUO_W  = RND_PROD_W - RND_SHIFT;
   localparam int RND_NEED_W = RND_QUO_W + 7;

   // register reset values
   localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = MAXREQ_W'(65536);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(1048576);

   // commands
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQ     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_LIMIT = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_MEMORY = 3'd2;
   localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;

   // operations broadcast to the cell row
   typedef logic [2:0] op_type;
   localparam op_type OP_NONE   = 3'd0;  // hold
   localparam op_type OP_START  = 3'd1;  // clear target/after marks
   localparam op_type OP_TAKE   = 3'd2;  // target becomes used
   localparam op_type OP_SPLIT  = 3'd3;  // target used, remainder inserted after it
   localparam op_type OP_APPEND = 3'd4;  // first empty cell gets a new block
   localparam op_type OP_MARK   = 3'd5;  // target becomes free
   localparam op_type OP_MRGN   = 3'd6;  // target absorbs its right neighbor
   localparam op_type OP_MRGP   = 3'd7;  // left neighbor absorbs the target

endpackage

`default_nettype wire

@@ rtl/core/first_fit_heap_allocator_unit.sv @@
// One request at a time; completion also waits out any response stall.
// Requests walk the row of MAX_BLOCKS cells, one cell per cycle; rejected
// sizes and null releases answer without the walk. Reset (synchronous)
// empties every cell at once; no clearing pass.
// Top level of the first-fit allocator: control, registers and the cell row.
// Depends on ffha_pkg and ffha_cell.
`default_nettype none

module first_fit_heap_allocator_unit #(
   parameter int MAX_BLOCKS      = ffha_pkg::DEF_MAX_BLOCKS,
   parameter int ARENA_ADDR_BITS = ffha_pkg::DEF_ARENA_ADDR_BITS,
   parameter int HEADER_BYTES    = ffha_pkg::DEF_HEADER_BYTES,
   parameter int ALIGN_BYTES     = ffha_pkg::DEF_ALIGN_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_cmd,
   input  wire logic [ffha_pkg::REQ_W-1:0]      req_request_size,
   input  wire logic [ffha_pkg::ADDR_W-1:0]     req_block_address,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ffha_pkg::STAT_W-1:0]          rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]          rsp_payload_address,
   input  wire logic                            csr_write,
   input  wire logic [ffha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffha_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ffha_pkg::*;

   localparam int SB  = (ARENA_ADDR_BITS + 1 > RND_Q_W) ? ARENA_ADDR_BITS + 1 : RND_Q_W;
   localparam int UCW = $clog2(MAX_BLOCKS + 1);
   localparam logic [SB-1:0]        HDR      = SB'(HEADER_BYTES);
   localparam logic [SB:0]          SPACE    = (SB + 1)'(1) << ARENA_ADDR_BITS;
   localparam logic [UCW-1:0]       BLK_MAX  = UCW'(MAX_BLOCKS);
   localparam logic [RND_MUL_W-1:0] RND_MUL  =
      RND_MUL_W'(((64'd1 << RND_SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
   localparam logic [RND_Q_W-1:0]   ALIGN_M1 = RND_Q_W'(ALIGN_BYTES - 1);

   // controller states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RND1   = 4'd1;
   localparam logic [3:0] S_RND2   = 4'd2;
   localparam logic [3:0] S_LAUNCH = 4'd3;
   localparam logic [3:0] S_WALK   = 4'd4;
   localparam logic [3:0] S_MRGN   = 4'd5;
   localparam logic [3:0] S_MRGP   = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;
   localparam logic [3:0] S_APPLY  = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic                    cmd_ff, cmd_in;
   logic [REQ_W-1:0]        req_ff, req_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [RND_PROD_W-1:0]   prod_ff, prod_in;
   logic [SB-1:0]           need_ff, need_in;
   logic [SB-1:0]           rem_ff, rem_in;
   logic                    pf_ff, pf_in;
   logic                    nf_ff, nf_in;
   op_type                  op_ff, op_in;
   logic [UCW-1:0]          ucnt_ff, ucnt_in;
   logic [SB-1:0]           atop_ff, atop_in;
   logic [MAXREQ_W-1:0]     maxreq_ff;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [STAT_W-1:0]       res_stat_ff, res_stat_in;
   logic [ADDR_W-1:0]       res_addr_ff, res_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_stat_ff, rsp_stat_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;

   op_type                  op;
   logic                    inject;

   // cell row wiring
   logic                    c_valid [MAX_BLOCKS];
   logic                    c_free  [MAX_BLOCKS];
   logic [SB-1:0]           c_size  [MAX_BLOCKS];
   logic                    c_tgt   [MAX_BLOCKS];
   logic                    p_vld   [MAX_BLOCKS+1];
   logic                    p_hit   [MAX_BLOCKS+1];
   logic [SB-1:0]           p_run   [MAX_BLOCKS+1];
   logic [SB-1:0]           p_toff  [MAX_BLOCKS+1];
   logic [SB-1:0]           p_tsize [MAX_BLOCKS+1];
   logic                    p_pf    [MAX_BLOCKS+1];
   logic                    p_nf    [MAX_BLOCKS+1];
   logic                    p_nseen [MAX_BLOCKS+1];
   logic                    p_lf    [MAX_BLOCKS+1];

   logic                    accept;
   logic                    reject;
   logic [RND_Q_W-1:0]      rnd_q;
   logic [RND_QUO_W-1:0]    rnd_quo;
   logic [RND_NEED_W-1:0]   rnd_need;
   logic                    has_spare;
   logic [SB:0]             split_min;
   logic [SB:0]             grow_end;
   logic [SB:0]             lim_eff;
   logic [SB-1:0]           tgt_addr;
   logic [SB-1:0]           top_addr;
   logic                    rsp_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_stat_ff;
   assign rsp_payload_address = rsp_addr_ff;

   // packet injected at the head of the row
   assign p_vld[0]   = inject;
   assign p_hit[0]   = 1'b0;
   assign p_run[0]   = '0;
   assign p_toff[0]  = '0;
   assign p_tsize[0] = '0;
   assign p_pf[0]    = 1'b0;
   assign p_nf[0]    = 1'b0;
   assign p_nseen[0] = 1'b0;
   assign p_lf[0]    = 1'b0;

   // the cell row
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic          l_valid, l_free, l_tgt, r_valid, r_free, r_tgt;
      logic [SB-1:0] l_size, r_size;
      if (i == 0) begin : g_head
         assign l_valid = 1'b1;
         assign l_free  = 1'b0;
         assign l_size  = '0;
         assign l_tgt   = 1'b0;
      end else begin : g_mid
         assign l_valid = c_valid[i-1];
         assign l_free  = c_free[i-1];
         assign l_size  = c_size[i-1];
         assign l_tgt   = c_tgt[i-1];
      end
      if (i == MAX_BLOCKS - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_free  = 1'b0;
         assign r_size  = '0;
         assign r_tgt   = 1'b0;
      end else begin : g_body
         assign r_valid = c_valid[i+1];
         assign r_free  = c_free[i+1];
         assign r_size  = c_size[i+1];
         assign r_tgt   = c_tgt[i+1];
      end
      ffha_cell #(
         .SIZE_BITS (SB),
         .HDR_BYTES (HEADER_BYTES)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op_code     (op),
         .op_need     (need_ff),
         .op_rem      (rem_ff),
         .key_release (cmd_ff),
         .key_addr    (SB'(addr_ff)),
         .left_valid  (l_valid),
         .left_free   (l_free),
         .left_size   (l_size),
         .left_tgt    (l_tgt),
         .right_valid (r_valid),
         .right_free  (r_free),
         .right_size  (r_size),
         .right_tgt   (r_tgt),
         .cell_valid  (c_valid[i]),
         .cell_free   (c_free[i]),
         .cell_size   (c_size[i]),
         .cell_tgt    (c_tgt[i]),
         .pin_vld     (p_vld[i]),
         .pin_hit     (p_hit[i]),
         .pin_run     (p_run[i]),
         .pin_toff    (p_toff[i]),
         .pin_tsize   (p_tsize[i]),
         .pin_pf      (p_pf[i]),
         .pin_nf      (p_nf[i]),
         .pin_nseen   (p_nseen[i]),
         .pin_lf      (p_lf[i]),
         .pout_vld    (p_vld[i+1]),
         .pout_hit    (p_hit[i+1]),
         .pout_run    (p_run[i+1]),
         .pout_toff   (p_toff[i+1]),
         .pout_tsize  (p_tsize[i+1]),
         .pout_pf     (p_pf[i+1]),
         .pout_nf     (p_nf[i+1]),
         .pout_nseen  (p_nseen[i+1]),
         .pout_lf     (p_lf[i+1])
      );
   end

   // size check and round-up to the alignment
   assign reject   = (req_ff == '0) || (req_ff > maxreq_ff);
   assign rnd_q    = {1'b0, req_ff} + ALIGN_M1;
   assign rnd_quo  = prod_ff[RND_PROD_W-1:RND_SHIFT];
   assign rnd_need = RND_NEED_W'(rnd_quo) * RND_NEED_W'(ALIGN_BYTES);

   // fit, split and growth checks on the returned packet
   assign has_spare = (ucnt_ff < BLK_MAX);
   assign split_min = {1'b0, need_ff} + {1'b0, HDR} + (SB + 1)'(MIN_TAIL_BYTES);
   assign grow_end  = {1'b0, atop_ff} + {1'b0, HDR} + {1'b0, need_ff};
   assign lim_eff   = ((SB + 1)'(limit_ff) > SPACE) ? SPACE : (SB + 1)'(limit_ff);
   assign tgt_addr  = p_toff[MAX_BLOCKS] + HDR;
   assign top_addr  = atop_ff + HDR;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // controller
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      req_in      = req_ff;
      addr_in     = addr_ff;
      prod_in     = prod_ff;
      need_in     = need_ff;
      rem_in      = rem_ff;
      pf_in       = pf_ff;
      nf_in       = nf_ff;
      op_in       = op_ff;
      ucnt_in     = ucnt_ff;
      atop_in     = atop_ff;
      res_stat_in = res_stat_ff;
      res_addr_in = res_addr_ff;
      op          = OP_NONE;
      inject      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_cmd;
               req_in  = req_request_size;
               addr_in = req_block_address;
               state_in = S_RND1;
            end
         end
         S_RND1: begin
            // rejected sizes and null releases answer at once
            res_addr_in = '0;
            if (cmd_ff == CMD_ALLOC) begin
               if (reject) begin
                  res_stat_in = ST_REJECTED;
                  state_in    = S_DONE;
               end else begin
                  prod_in  = RND_PROD_W'(rnd_q) * RND_PROD_W'(RND_MUL);
                  state_in = S_RND2;
               end
            end else if (addr_ff == '0) begin
               res_stat_in = ST_RELEASED;
               state_in    = S_DONE;
            end else begin
               state_in = S_LAUNCH;
            end
         end
         S_RND2: begin
            need_in  = SB'(rnd_need);
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            op       = OP_START;
            inject   = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            // decide on the returned packet; the row update follows in S_APPLY,
            // once the last cell's target/after marks have settled
            if (p_vld[MAX_BLOCKS]) begin
               res_addr_in = '0;
               if (cmd_ff == CMD_ALLOC) begin
                  if (p_hit[MAX_BLOCKS]) begin
                     res_stat_in = ST_ALLOCATED;
                     res_addr_in = ADDR_W'(tgt_addr);
                     if (({1'b0, p_tsize[MAX_BLOCKS]} >= split_min) && has_spare) begin
                        op_in   = OP_SPLIT;
                        ucnt_in = ucnt_ff + 1'b1;
                     end else begin
                        op_in = OP_TAKE;
                     end
                  end else if ((grow_end <= lim_eff) && has_spare) begin
                     op_in       = OP_APPEND;
                     ucnt_in     = ucnt_ff + 1'b1;
                     atop_in     = SB'(grow_end);
                     res_stat_in = ST_ALLOCATED;
                     res_addr_in = ADDR_W'(top_addr);
                  end else begin
                     op_in       = OP_NONE;
                     res_stat_in = ST_NO_MEMORY;
                  end
                  state_in = S_APPLY;
               end else begin
                  if (p_hit[MAX_BLOCKS]) begin
                     op_in       = OP_MARK;
                     pf_in       = p_pf[MAX_BLOCKS];
                     nf_in       = p_nf[MAX_BLOCKS];
                     res_stat_in = ST_RELEASED;
                     state_in    = S_APPLY;
                  end else begin
                     res_stat_in = ST_UNKNOWN;
                     state_in    = S_DONE;
                  end
               end
            end
         end
         S_APPLY: begin
            op = op_ff;
            if ((op_ff == OP_MARK) && nf_ff)      state_in = S_MRGN;
            else if ((op_ff == OP_MARK) && pf_ff) state_in = S_MRGP;
            else                                  state_in = S_DONE;
         end
         S_MRGN: begin
            op       = OP_MRGN;
            ucnt_in  = ucnt_ff - 1'b1;
            state_in = pf_ff ? S_MRGP : S_DONE;
         end
         S_MRGP: begin
            op       = OP_MRGP;
            ucnt_in  = ucnt_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // remainder size for a split, prepared during the walk
      rem_in = p_tsize[MAX_BLOCKS] - need_ff - HDR;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = res_stat_ff;
         rsp_addr_in  = res_addr_ff;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ucnt_ff      <= '0;
         atop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         maxreq_ff    <= MAXREQ_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         ucnt_ff      <= ucnt_in;
         atop_ff      <= atop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_REQ:     maxreq_ff <= csr_wdata[MAXREQ_W-1:0];
               CSR_ARENA_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      req_ff      <= req_in;
      addr_ff     <= addr_in;
      prod_ff     <= prod_in;
      need_ff     <= need_in;
      rem_ff      <= rem_in;
      pf_ff       <= pf_in;
      nf_ff       <= nf_in;
      op_ff       <= op_in;
      res_stat_ff <= res_stat_in;
      res_addr_ff <= res_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_addr_ff <= rsp_addr_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/ffha_cell.sv @@
// One cell of the block row: holds one block descriptor in address order.
// Processes the walking request packet and neighbor shifts; uses ffha_pkg.
`default_nettype none

module ffha_cell #(
   parameter int SIZE_BITS = 21,
   parameter int HDR_BYTES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // broadcast operation and keys
   input  wire ffha_pkg::op_type      op_code,
   input  wire logic [SIZE_BITS-1:0]  op_need,
   input  wire logic [SIZE_BITS-1:0]  op_rem,
   input  wire logic                  key_release,
   input  wire logic [SIZE_BITS-1:0]  key_addr,
   // neighbors
   input  wire logic                  left_valid,
   input  wire logic                  left_free,
   input  wire logic [SIZE_BITS-1:0]  left_size,
   input  wire logic                  left_tgt,
   input  wire logic                  right_valid,
   input  wire logic                  right_free,
   input  wire logic [SIZE_BITS-1:0]  right_size,
   input  wire logic                  right_tgt,
   output logic                       cell_valid,
   output logic                       cell_free,
   output logic [SIZE_BITS-1:0]       cell_size,
   output logic                       cell_tgt,
   // request packet from the left
   input  wire logic                  pin_vld,
   input  wire logic                  pin_hit,
   input  wire logic [SIZE_BITS-1:0]  pin_run,
   input  wire logic [SIZE_BITS-1:0]  pin_toff,
   input  wire logic [SIZE_BITS-1:0]  pin_tsize,
   input  wire logic                  pin_pf,
   input  wire logic                  pin_nf,
   input  wire logic                  pin_nseen,
   input  wire logic                  pin_lf,
   // request packet to the right
   output logic                       pout_vld,
   output logic                       pout_hit,
   output logic [SIZE_BITS-1:0]       pout_run,
   output logic [SIZE_BITS-1:0]       pout_toff,
   output logic [SIZE_BITS-1:0]       pout_tsize,
   output logic                       pout_pf,
   output logic                       pout_nf,
   output logic                       pout_nseen,
   output logic                       pout_lf
);

   import ffha_pkg::*;

   localparam logic [SIZE_BITS-1:0] HDR = SIZE_BITS'(HDR_BYTES);

   logic                 valid_ff, valid_in;
   logic                 free_ff, free_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 tgt_ff, tgt_in;
   logic                 aft_ff, aft_in;

   logic                 pk_vld_ff;
   logic                 pk_hit_ff;
   logic [SIZE_BITS-1:0] pk_run_ff;
   logic [SIZE_BITS-1:0] pk_toff_ff;
   logic [SIZE_BITS-1:0] pk_tsize_ff;
   logic                 pk_pf_ff;
   logic                 pk_nf_ff;
   logic                 pk_nseen_ff;
   logic                 pk_lf_ff;

   logic                 match;
   logic                 now_hit;
   logic                 first_after;
   logic [SIZE_BITS-1:0] payload_off;

   // block lookup against the packet's running offset
   assign payload_off = pk_run_ff + HDR;
   assign match       = valid_ff && (key_release ? (payload_off == key_addr)
                                                 : (free_ff && (size_ff >= op_need)));
   assign now_hit     = pk_vld_ff && !pk_hit_ff && match;
   assign first_after = pk_hit_ff && !pk_nseen_ff;

   // outgoing packet
   assign pout_vld   = pk_vld_ff;
   assign pout_hit   = pk_hit_ff || now_hit;
   assign pout_run   = valid_ff ? (payload_off + size_ff) : pk_run_ff;
   assign pout_toff  = now_hit ? pk_run_ff : pk_toff_ff;
   assign pout_tsize = now_hit ? size_ff : pk_tsize_ff;
   assign pout_pf    = now_hit ? pk_lf_ff : pk_pf_ff;
   assign pout_nf    = first_after ? (valid_ff && free_ff) : pk_nf_ff;
   assign pout_nseen = pk_nseen_ff || pk_hit_ff;
   assign pout_lf    = valid_ff && free_ff;

   assign cell_valid = valid_ff;
   assign cell_free  = free_ff;
   assign cell_size  = size_ff;
   assign cell_tgt   = tgt_ff;

   // target / after marks
   always_comb begin
      tgt_in = tgt_ff;
      aft_in = aft_ff;
      if (op_code == OP_START) begin
         tgt_in = 1'b0;
         aft_in = 1'b0;
      end else if (pk_vld_ff) begin
         if (now_hit) tgt_in = 1'b1;
         if (pk_hit_ff) aft_in = 1'b1;
      end
   end

   // descriptor update
   always_comb begin
      valid_in = valid_ff;
      free_in  = free_ff;
      size_in  = size_ff;
      case (op_code)
         OP_TAKE: begin
            if (tgt_ff) free_in = 1'b0;
         end
         OP_SPLIT: begin
            if (tgt_ff) begin
               size_in = op_need;
               free_in = 1'b0;
            end else if (aft_ff) begin
               if (left_tgt) begin
                  valid_in = 1'b1;
                  free_in  = 1'b1;
                  size_in  = op_rem;
               end else begin
                  valid_in = left_valid;
                  free_in  = left_free;
                  size_in  = left_size;
               end
            end
         end
         OP_APPEND: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               free_in  = 1'b0;
               size_in  = op_need;
            end
         end
         OP_MARK: begin
            if (tgt_ff) free_in = 1'b1;
         end
         OP_MRGN: begin
            if (tgt_ff) begin
               size_in = size_ff + HDR + right_size;
            end else if (aft_ff) begin
               valid_in = right_valid;
               free_in  = right_free;
               size_in  = right_size;
            end
         end
         OP_MRGP: begin
            if (right_tgt) begin
               size_in = size_ff + HDR + right_size;
            end else if (tgt_ff || aft_ff) begin
               valid_in = right_valid;
               free_in  = right_free;
               size_in  = right_size;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tgt_ff    <= 1'b0;
         aft_ff    <= 1'b0;
         pk_vld_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         tgt_ff    <= tgt_in;
         aft_ff    <= aft_in;
         pk_vld_ff <= pin_vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      size_ff     <= size_in;
      pk_hit_ff   <= pin_hit;
      pk_run_ff   <= pin_run;
      pk_toff_ff  <= pin_toff;
      pk_tsize_ff <= pin_tsize;
      pk_pf_ff    <= pin_pf;
      pk_nf_ff    <= pin_nf;
      pk_nseen_ff <= pin_nseen;
      pk_lf_ff    <= pin_lf;
   end

endmodule

`default_nettype wire
